>>> design/x86_instruction_encoder_defines.svh
// Assertion macros shared by the encoder checker.
// No dependencies; the including module must provide clock and reset.
`ifndef X86_INSTRUCTION_ENCODER_DEFINES_SVH
`define X86_INSTRUCTION_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define X86E_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("x86 encoder check failed");

// Next-cycle implication, disabled during reset.
`define X86E_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("x86 encoder check failed");

`endif

>>> design/x86e_pkg.sv
// Shared types and constants of the x86-64 instruction encoder.
// No dependencies; used by every module of the encoder.
`timescale 1ns / 1ps

package x86e_pkg;

   localparam int unsigned MaxBytes = 10;
   localparam int unsigned LenWidth = 4;

   // operation codes
   localparam logic [3:0] OP_ADD32  = 4'd0;
   localparam logic [3:0] OP_ADD8   = 4'd1;
   localparam logic [3:0] OP_CALL   = 4'd2;
   localparam logic [3:0] OP_LEA    = 4'd3;
   localparam logic [3:0] OP_MOV64  = 4'd4;
   localparam logic [3:0] OP_MOVMEM = 4'd5;
   localparam logic [3:0] OP_MOV16  = 4'd6;
   localparam logic [3:0] OP_MOVI32 = 4'd7;
   localparam logic [3:0] OP_MOVI64 = 4'd8;
   localparam logic [3:0] OP_MOVZX  = 4'd9;
   localparam logic [3:0] OP_POP    = 4'd10;
   localparam logic [3:0] OP_PUSH   = 4'd11;
   localparam logic [3:0] OP_RET    = 4'd12;

   // encoding bytes
   localparam logic [7:0] BYTE_REX      = 8'h40;
   localparam logic [7:0] BYTE_OPSIZE   = 8'h66;
   localparam logic [7:0] BYTE_ADD32    = 8'h01;
   localparam logic [7:0] BYTE_ADD8     = 8'h00;
   localparam logic [7:0] BYTE_GRP5     = 8'hFF;
   localparam logic [7:0] BYTE_LEA      = 8'h8D;
   localparam logic [7:0] BYTE_MOV_LOAD = 8'h8B;
   localparam logic [7:0] BYTE_MOV_STOR = 8'h89;
   localparam logic [7:0] BYTE_MOV_IMM  = 8'hB8;
   localparam logic [7:0] BYTE_ESCAPE   = 8'h0F;
   localparam logic [7:0] BYTE_MOVZX_W  = 8'hB7;
   localparam logic [7:0] BYTE_POP      = 8'h58;
   localparam logic [7:0] BYTE_PUSH     = 8'h50;
   localparam logic [7:0] BYTE_RET      = 8'hC3;
   localparam logic [7:0] MODRM_REG     = 8'hC0;
   localparam logic [7:0] MODRM_CALL    = 8'hD0;
   localparam logic [7:0] MODRM_DISP8   = 8'h40;
   localparam logic [7:0] MODRM_DISP32  = 8'h80;

   typedef struct packed {
      logic [3:0]         operation;
      logic [3:0]         target_reg;
      logic [3:0]         other_reg;
      logic               store_dir;
      logic signed [31:0] displacement;
      logic [63:0]        immediate;
   } req_type;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       last;
   } rsp_type;

   // one fully encoded instruction, byte 0 first
   typedef struct packed {
      logic [LenWidth-1:0]          len;
      logic [MaxBytes-1:0][7:0]     bytes;
   } enc_type;

endpackage

>>> design/x86e_encode.sv
// Combinational encoder: one request to its full byte string and length.
// Depends on x86e_pkg.
`timescale 1ns / 1ps

module x86e_encode (
   input  x86e_pkg::req_type req,
   output x86e_pkg::enc_type enc
);

   logic                        rex_cand, rex_w, pfx66, has_modrm, is_mem;
   logic [3:0]                  rex_r, rex_b;
   logic [7:0]                  opc0, opc1, modrm;
   logic [1:0]                  n_opc;
   logic [3:0]                  n_imm;
   logic [2:0]                  n_disp;
   logic [7:0]                  mem_mode;
   logic [x86e_pkg::LenWidth-1:0] pos;
   logic [x86e_pkg::LenWidth-1:0] slot;
   logic [31:0]                 disp;
   logic                        disp8;

   assign disp  = req.displacement;
   assign disp8 = (&disp[31:7]) | ~(|disp[31:7]);

   always_comb begin
      rex_cand  = 1'b0;
      rex_w     = 1'b0;
      rex_r     = 4'd0;
      rex_b     = 4'd0;
      pfx66     = 1'b0;
      opc0      = 8'h00;
      opc1      = 8'h00;
      n_opc     = 2'd0;
      has_modrm = 1'b0;
      is_mem    = 1'b0;
      modrm     = 8'h00;
      n_imm     = 4'd0;
      unique case (req.operation) inside
         x86e_pkg::OP_ADD32, x86e_pkg::OP_ADD8: begin
            rex_cand  = 1'b1;
            rex_r     = req.other_reg;
            rex_b     = req.target_reg;
            opc0      = (req.operation == x86e_pkg::OP_ADD32) ?
                        x86e_pkg::BYTE_ADD32 : x86e_pkg::BYTE_ADD8;
            n_opc     = 2'd1;
            has_modrm = 1'b1;
            modrm     = x86e_pkg::MODRM_REG | {2'b00, req.other_reg[2:0], req.target_reg[2:0]};
         end
         x86e_pkg::OP_CALL: begin
            rex_cand  = 1'b1;
            rex_b     = req.target_reg;
            opc0      = x86e_pkg::BYTE_GRP5;
            n_opc     = 2'd1;
            has_modrm = 1'b1;
            modrm     = x86e_pkg::MODRM_CALL | {5'd0, req.target_reg[2:0]};
         end
         x86e_pkg::OP_LEA: begin
            rex_cand = 1'b1;
            rex_r    = req.target_reg;
            rex_b    = req.other_reg;
            opc0     = x86e_pkg::BYTE_LEA;
            n_opc    = 2'd1;
            is_mem   = 1'b1;
         end
         x86e_pkg::OP_MOV64: begin
            rex_cand  = 1'b1;
            rex_w     = 1'b1;
            rex_r     = req.other_reg;
            rex_b     = req.target_reg;
            opc0      = x86e_pkg::BYTE_MOV_STOR;
            n_opc     = 2'd1;
            has_modrm = 1'b1;
            modrm     = x86e_pkg::MODRM_REG | {2'b00, req.other_reg[2:0], req.target_reg[2:0]};
         end
         x86e_pkg::OP_MOVMEM, x86e_pkg::OP_MOV16: begin
            pfx66    = (req.operation == x86e_pkg::OP_MOV16);
            rex_cand = 1'b1;
            rex_r    = req.target_reg;
            rex_b    = req.other_reg;
            opc0     = req.store_dir ? x86e_pkg::BYTE_MOV_STOR : x86e_pkg::BYTE_MOV_LOAD;
            n_opc    = 2'd1;
            is_mem   = 1'b1;
         end
         x86e_pkg::OP_MOVI32, x86e_pkg::OP_MOVI64: begin
            rex_cand = 1'b1;
            rex_w    = (req.operation == x86e_pkg::OP_MOVI64);
            rex_b    = req.target_reg;
            opc0     = x86e_pkg::BYTE_MOV_IMM | {5'd0, req.target_reg[2:0]};
            n_opc    = 2'd1;
            n_imm    = rex_w ? 4'd8 : 4'd4;
         end
         x86e_pkg::OP_MOVZX: begin
            rex_cand = 1'b1;
            rex_r    = req.target_reg;
            rex_b    = req.other_reg;
            opc0     = x86e_pkg::BYTE_ESCAPE;
            opc1     = x86e_pkg::BYTE_MOVZX_W;
            n_opc    = 2'd2;
            is_mem   = 1'b1;
         end
         x86e_pkg::OP_POP: begin
            rex_cand = 1'b1;
            rex_b    = req.target_reg;
            opc0     = x86e_pkg::BYTE_POP | {5'd0, req.target_reg[2:0]};
            n_opc    = 2'd1;
         end
         x86e_pkg::OP_PUSH: begin
            rex_cand = 1'b1;
            rex_b    = req.target_reg;
            opc0     = x86e_pkg::BYTE_PUSH | {5'd0, req.target_reg[2:0]};
            n_opc    = 2'd1;
         end
         x86e_pkg::OP_RET: begin
            opc0  = x86e_pkg::BYTE_RET;
            n_opc = 2'd1;
         end
         default: begin
            // unused codes encode to nothing
            n_opc = 2'd0;
         end
      endcase

      // memory ModRM: mode from displacement size, never a SIB byte
      mem_mode = x86e_pkg::MODRM_DISP32;
      n_disp   = 3'd4;
      if (disp == 32'd0) begin
         mem_mode = 8'h00;
         n_disp   = 3'd0;
      end else if (disp8) begin
         mem_mode = x86e_pkg::MODRM_DISP8;
         n_disp   = 3'd1;
      end
      if (is_mem) begin
         has_modrm = 1'b1;
         modrm     = mem_mode | {2'b00, req.target_reg[2:0], req.other_reg[2:0]};
      end else begin
         n_disp = 3'd0;
      end

      // assemble in memory order
      enc.bytes = '0;
      pos       = '0;
      slot      = '0;
      if (pfx66) begin
         enc.bytes[pos] = x86e_pkg::BYTE_OPSIZE;
         pos = pos + 1'b1;
      end
      if (rex_cand && (rex_w || rex_r[3] || rex_b[3])) begin
         enc.bytes[pos] = x86e_pkg::BYTE_REX | {4'd0, rex_w, rex_r[3], 1'b0, rex_b[3]};
         pos = pos + 1'b1;
      end
      if (n_opc != 2'd0) begin
         enc.bytes[pos] = opc0;
         pos = pos + 1'b1;
      end
      if (n_opc == 2'd2) begin
         enc.bytes[pos] = opc1;
         pos = pos + 1'b1;
      end
      if (has_modrm) begin
         enc.bytes[pos] = modrm;
         pos = pos + 1'b1;
      end
      for (int i = 0; i < 4; i++) begin
         slot = pos + x86e_pkg::LenWidth'(i);
         if ((3'(i) < n_disp) && (slot < x86e_pkg::LenWidth'(x86e_pkg::MaxBytes))) begin
            enc.bytes[slot] = disp[8*i +: 8];
         end
      end
      pos = pos + {1'b0, n_disp};
      for (int i = 0; i < 8; i++) begin
         slot = pos + x86e_pkg::LenWidth'(i);
         if ((4'(i) < n_imm) && (slot < x86e_pkg::LenWidth'(x86e_pkg::MaxBytes))) begin
            enc.bytes[slot] = req.immediate[8*i +: 8];
         end
      end
      pos     = pos + n_imm;
      enc.len = pos;
   end

endmodule

>>> design/x86e_serial.sv
// Output stage: holds one encoded instruction and sends it a byte per beat.
// Depends on x86e_pkg.
`timescale 1ns / 1ps

module x86e_serial (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  x86e_pkg::enc_type enc,
   output logic              free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output x86e_pkg::rsp_type rsp_item
);

   x86e_pkg::enc_type             buf_ff, buf_in;
   logic [x86e_pkg::LenWidth-1:0] idx_ff, idx_in;
   logic                          valid_ff, valid_in;
   logic                          at_last, done;

   assign at_last = (idx_ff == buf_ff.len - 1'b1);
   assign done    = valid_ff && !rsp_stall && at_last;
   assign free    = !valid_ff || done;

   always_comb begin
      buf_in   = buf_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         buf_in   = enc;
         idx_in   = '0;
         valid_in = 1'b1;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (valid_ff && !rsp_stall) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      idx_ff <= idx_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_item.code_byte = buf_ff.bytes[idx_ff];
   assign rsp_item.last      = at_last;

endmodule

>>> design/x86_instruction_encoder.sv
// x86-64 instruction encoder. Each request item names an instruction form
// (operation 0..12) and its operands; the block answers with the machine code
// bytes of that instruction, one rsp item per byte in memory order, with last
// set on the final byte. Codes 13..15 produce no bytes at all. An item gives
// as many rsp items as its encoding has bytes, 1 to 10 (mov r64,imm64 is the
// longest); the byte-wide output stage shifts out one byte per cycle while
// rsp_stall is low. A 1-byte item such as ret can therefore stream at one per
// cycle while rsp_stall is low. After acceptance an item waits in the request
// register, then its encoded form is loaded into the output buffer, from which
// its bytes are sent. The next request is taken while the previous
// instruction is still being sent; the input stalls only when the request
// register holds an item that cannot yet move into the output buffer.
// Depends on x86e_pkg, x86e_encode and x86e_serial.
`timescale 1ns / 1ps

module x86_instruction_encoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  x86e_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output x86e_pkg::rsp_type rsp_item
);

   // request register
   x86e_pkg::req_type in_ff, in_in;
   logic              in_valid_ff, in_valid_in;

   x86e_pkg::enc_type enc;
   logic              free;
   logic              empty_enc;   // form with no bytes, simply dropped
   logic              load;
   logic              in_move;
   logic              accept;

   x86e_encode u_encode (
      .req (in_ff),
      .enc (enc)
   );

   assign empty_enc = (enc.len == '0);
   assign load      = in_valid_ff && !empty_enc && free;
   assign in_move   = in_valid_ff && (empty_enc || free);
   assign req_stall = in_valid_ff && !in_move;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_in       = in_ff;
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_in       = req_item;
         in_valid_in = 1'b1;
      end else if (in_move) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // byte shifter and output register
   x86e_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .enc       (enc),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

>>> design/x86e_checker.sv
// Port-level checks of the x86-64 instruction encoder, bound to its top level.
// Depends on x86e_pkg and x86_instruction_encoder_defines.svh.
`timescale 1ns / 1ps
`include "x86_instruction_encoder_defines.svh"

module x86e_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input x86e_pkg::req_type req_item,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input x86e_pkg::rsp_type rsp_item
);

   // non-last bytes sent since the previous last byte
   logic [3:0] beats_ff, beats_in;
   logic       rsp_take;

   assign rsp_take = rsp_valid && !rsp_stall;

   always_comb begin
      beats_in = beats_ff;
      if (rsp_take) begin
         if (rsp_item.last) begin
            beats_in = 4'd0;
         end else if (beats_ff != 4'd15) begin
            beats_in = beats_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beats_ff <= 4'd0;
      end else begin
         beats_ff <= beats_in;
      end
   end

   `X86E_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req_item))
   `X86E_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))
   `X86E_ASSERT_NOW(a_stall_busy, req_stall, rsp_valid)
   `X86E_ASSERT_NOW(a_max_len, rsp_take && !rsp_item.last, beats_ff < 4'd9)
   `X86E_ASSERT_NEXT(a_idle_free, !rsp_valid && !req_valid && !req_stall, !req_stall)

endmodule

bind x86_instruction_encoder x86e_checker u_checker (.*);
